// File: sv/qrr_pkg.sv
`timescale 1ns / 1ps

package qrr_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ROOT_WIDTH = 34;

  localparam int DISC_WIDTH = 2 * COEF_WIDTH + 1;
  localparam int DSGN_WIDTH = 2 * COEF_WIDTH + 2;
  localparam int SQRT_WIDTH = COEF_WIDTH + FRAC_BITS + 1;
  localparam int RAD_WIDTH  = 2 * SQRT_WIDTH;
  localparam int NB_WIDTH   = COEF_WIDTH + FRAC_BITS + 1;
  localparam int NUM_WIDTH  = COEF_WIDTH + FRAC_BITS + 3;
  localparam int DIVR_WIDTH = COEF_WIDTH + 1;
  localparam int CMP_WIDTH  = (NUM_WIDTH + 1 > ROOT_WIDTH) ? NUM_WIDTH + 1 : ROOT_WIDTH;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_TWO    = 2'd2,
    ST_AZERO  = 2'd3
  } status_e;

  typedef struct packed {
    status_e                     status;
    logic signed [NB_WIDTH-1:0]  nb;
    logic [COEF_WIDTH-1:0]       amag;
    logic                        aneg;
  } sq_ctx_t;

  typedef struct packed {
    logic [RAD_WIDTH-1:0]    rad;
    logic [SQRT_WIDTH+1:0]   rem;
    logic [SQRT_WIDTH-1:0]   res;
  } sq_work_t;

  typedef struct packed {
    status_e                 status;
    logic                    neg_hi;
    logic                    neg_lo;
    logic [DIVR_WIDTH-1:0]   divisor;
  } dv_ctx_t;

  typedef struct packed {
    logic [NUM_WIDTH-1:0]    num;
    logic [NUM_WIDTH-1:0]    quo;
    logic [DIVR_WIDTH-1:0]   rem;
  } dv_lane_t;

  typedef struct packed {
    logic valid;
  } hs_t;

endpackage

// File: sv/qrr_if.sv
`timescale 1ns / 1ps

interface qrr_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [qrr_pkg::COEF_WIDTH-1:0]     coef_a;
  logic signed [qrr_pkg::COEF_WIDTH-1:0]     coef_b;
  logic signed [qrr_pkg::COEF_WIDTH-1:0]     coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrr_out_if;
  logic                                      valid;
  logic                                      ready;
  logic [1:0]                                root_status;
  logic signed [qrr_pkg::ROOT_WIDTH-1:0]     root_high;
  logic signed [qrr_pkg::ROOT_WIDTH-1:0]     root_low;
  modport source (output valid, root_status, root_high, root_low, input ready);
  modport sink   (input valid, root_status, root_high, root_low, output ready);
endinterface

// File: sv/qrr_sqrt_cell.sv
`timescale 1ns / 1ps

module qrr_sqrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qrr_pkg::hs_t      up_i,
  output logic              up_ready_o,
  input  qrr_pkg::sq_ctx_t  ctx_i,
  input  qrr_pkg::sq_work_t work_i,
  output qrr_pkg::hs_t      dn_o,
  input  logic              dn_ready_i,
  output qrr_pkg::sq_ctx_t  ctx_o,
  output qrr_pkg::sq_work_t work_o
);
  import qrr_pkg::*;

  logic                  v_q;
  sq_ctx_t               ctx_q;
  sq_work_t              work_q, work_d;
  logic [SQRT_WIDTH+3:0] rem2, trial;
  logic                  adv;

  assign adv = !v_q || dn_ready_i;
  assign up_ready_o = adv;

  always_comb begin
    rem2  = {work_i.rem, work_i.rad[RAD_WIDTH-1 -: 2]};
    trial = {2'b00, work_i.res, 2'b01};
    work_d.rad = {work_i.rad[RAD_WIDTH-3:0], 2'b00};
    if (rem2 >= trial) begin
      work_d.rem = (SQRT_WIDTH + 2)'(rem2 - trial);
      work_d.res = {work_i.res[SQRT_WIDTH-2:0], 1'b1};
    end else begin
      work_d.rem = (SQRT_WIDTH + 2)'(rem2);
      work_d.res = {work_i.res[SQRT_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && up_i.valid) begin
      ctx_q  <= ctx_i;
      work_q <= work_d;
    end
  end

  assign dn_o.valid = v_q;
  assign ctx_o  = ctx_q;
  assign work_o = work_q;

endmodule

// File: sv/qrr_div_cell.sv
`timescale 1ns / 1ps

module qrr_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qrr_pkg::hs_t      up_i,
  output logic              up_ready_o,
  input  qrr_pkg::dv_ctx_t  ctx_i,
  input  qrr_pkg::dv_lane_t hi_i,
  input  qrr_pkg::dv_lane_t lo_i,
  output qrr_pkg::hs_t      dn_o,
  input  logic              dn_ready_i,
  output qrr_pkg::dv_ctx_t  ctx_o,
  output qrr_pkg::dv_lane_t hi_o,
  output qrr_pkg::dv_lane_t lo_o
);
  import qrr_pkg::*;

  logic     v_q, adv;
  dv_ctx_t  ctx_q;
  dv_lane_t hi_q, lo_q, hi_d, lo_d;

  function automatic dv_lane_t step(input dv_lane_t l, input logic [DIVR_WIDTH-1:0] y);
    dv_lane_t              r;
    logic [DIVR_WIDTH:0]   rem2;
    rem2  = {l.rem, l.num[NUM_WIDTH-1]};
    r.num = {l.num[NUM_WIDTH-2:0], 1'b0};
    if (rem2 >= {1'b0, y}) begin
      r.rem = DIVR_WIDTH'(rem2 - {1'b0, y});
      r.quo = {l.quo[NUM_WIDTH-2:0], 1'b1};
    end else begin
      r.rem = DIVR_WIDTH'(rem2);
      r.quo = {l.quo[NUM_WIDTH-2:0], 1'b0};
    end
    return r;
  endfunction

  assign adv = !v_q || dn_ready_i;
  assign up_ready_o = adv;
  assign hi_d = step(hi_i, ctx_i.divisor);
  assign lo_d = step(lo_i, ctx_i.divisor);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && up_i.valid) begin
      ctx_q <= ctx_i;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
    end
  end

  assign dn_o.valid = v_q;
  assign ctx_o = ctx_q;
  assign hi_o  = hi_q;
  assign lo_o  = lo_q;

endmodule

// File: sv/quadratic_real_roots_unit.sv
`timescale 1ns / 1ps

// Real roots of a*x^2 + b*x + c for signed coefficients, one result transaction per
// input transaction, in order. A new transaction is taken every cycle until a stalled
// output has filled the chain. The pipeline is COEF_WIDTH + FRAC_BITS + 1 square-root
// cells plus COEF_WIDTH + FRAC_BITS + 3 divider cells plus the prep, numerator and
// output stages; the square root yields one bit per cell and the dividers are restoring.
// Empty cells advance under a stall, so input is taken until the chain is full.
// Roots are signed fixed point with FRAC_BITS fraction bits, larger first; status 3
// marks a zero quadratic coefficient and status 0 no real roots, both with zero roots.
module quadratic_real_roots_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrr_in_if.sink     in_i,
  qrr_out_if.source  out_o
);
  import qrr_pkg::*;

  hs_t      sq_hs  [0:SQRT_WIDTH];
  logic     sq_rdy [0:SQRT_WIDTH];
  sq_ctx_t  sq_ctx [0:SQRT_WIDTH];
  sq_work_t sq_wk  [0:SQRT_WIDTH];

  hs_t      dv_hs  [0:NUM_WIDTH];
  logic     dv_rdy [0:NUM_WIDTH];
  dv_ctx_t  dv_ctx [0:NUM_WIDTH];
  dv_lane_t dv_hi  [0:NUM_WIDTH];
  dv_lane_t dv_lo  [0:NUM_WIDTH];

  // prep stage
  logic                         pv_q, p_adv;
  sq_ctx_t                      pctx_q, pctx_d;
  sq_work_t                     pwk_q, pwk_d;
  logic signed [DSGN_WIDTH-1:0] disc;
  logic signed [2*COEF_WIDTH-1:0] bb, ac;

  assign p_adv = !pv_q || sq_rdy[0];
  assign in_i.ready = p_adv;

  always_comb begin
    bb   = in_i.coef_b * in_i.coef_b;
    ac   = in_i.coef_a * in_i.coef_c;
    disc = DSGN_WIDTH'(bb) - (DSGN_WIDTH'(ac) <<< 2);
    priority if (in_i.coef_a == '0) pctx_d.status = ST_AZERO;
    else if (disc[DSGN_WIDTH-1])    pctx_d.status = ST_NONE;
    else if (disc == '0)            pctx_d.status = ST_DOUBLE;
    else                            pctx_d.status = ST_TWO;
    pctx_d.nb   = -(NB_WIDTH'(in_i.coef_b) <<< FRAC_BITS);
    pctx_d.aneg = in_i.coef_a[COEF_WIDTH-1];
    pctx_d.amag = pctx_d.aneg ? COEF_WIDTH'(-in_i.coef_a) : COEF_WIDTH'(in_i.coef_a);
    pwk_d.rad   = RAD_WIDTH'({disc[DISC_WIDTH-1:0], {(2*FRAC_BITS){1'b0}}});
    pwk_d.rem   = '0;
    pwk_d.res   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (p_adv) begin
      pv_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_adv && in_i.valid) begin
      pctx_q <= pctx_d;
      pwk_q  <= pwk_d;
    end
  end

  assign sq_hs[0].valid = pv_q;
  assign sq_ctx[0] = pctx_q;
  assign sq_wk[0]  = pwk_q;

  for (genvar k = 0; k < SQRT_WIDTH; k++) begin : g_sq
    qrr_sqrt_cell u_cell (
      .clk_i, .rst_ni,
      .up_i       (sq_hs[k]),
      .up_ready_o (sq_rdy[k]),
      .ctx_i      (sq_ctx[k]),
      .work_i     (sq_wk[k]),
      .dn_o       (sq_hs[k+1]),
      .dn_ready_i (sq_rdy[k+1]),
      .ctx_o      (sq_ctx[k+1]),
      .work_o     (sq_wk[k+1])
    );
  end

  // numerator stage
  logic                        mv_q, m_adv;
  dv_ctx_t                     mctx_q, mctx_d;
  dv_lane_t                    mhi_q, mlo_q, mhi_d, mlo_d;
  logic signed [NUM_WIDTH-1:0] n_hi, n_lo, s_ext;
  logic [NUM_WIDTH-1:0]        mag_hi, mag_lo;

  assign m_adv = !mv_q || dv_rdy[0];
  assign sq_rdy[SQRT_WIDTH] = m_adv;

  always_comb begin
    s_ext  = NUM_WIDTH'(signed'({1'b0, sq_wk[SQRT_WIDTH].res}));
    n_hi   = NUM_WIDTH'(sq_ctx[SQRT_WIDTH].nb) + s_ext;
    n_lo   = NUM_WIDTH'(sq_ctx[SQRT_WIDTH].nb) - s_ext;
    mag_hi = n_hi[NUM_WIDTH-1] ? NUM_WIDTH'(-n_hi) : NUM_WIDTH'(n_hi);
    mag_lo = n_lo[NUM_WIDTH-1] ? NUM_WIDTH'(-n_lo) : NUM_WIDTH'(n_lo);
    mctx_d.status  = sq_ctx[SQRT_WIDTH].status;
    mctx_d.neg_hi  = n_hi[NUM_WIDTH-1] ^ sq_ctx[SQRT_WIDTH].aneg;
    mctx_d.neg_lo  = n_lo[NUM_WIDTH-1] ^ sq_ctx[SQRT_WIDTH].aneg;
    mctx_d.divisor = {sq_ctx[SQRT_WIDTH].amag, 1'b0};
    mhi_d.num = mag_hi + NUM_WIDTH'(sq_ctx[SQRT_WIDTH].amag);
    mlo_d.num = mag_lo + NUM_WIDTH'(sq_ctx[SQRT_WIDTH].amag);
    mhi_d.quo = '0;
    mlo_d.quo = '0;
    mhi_d.rem = '0;
    mlo_d.rem = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (m_adv) begin
      mv_q <= sq_hs[SQRT_WIDTH].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_adv && sq_hs[SQRT_WIDTH].valid) begin
      mctx_q <= mctx_d;
      mhi_q  <= mhi_d;
      mlo_q  <= mlo_d;
    end
  end

  assign dv_hs[0].valid = mv_q;
  assign dv_ctx[0] = mctx_q;
  assign dv_hi[0]  = mhi_q;
  assign dv_lo[0]  = mlo_q;

  for (genvar j = 0; j < NUM_WIDTH; j++) begin : g_dv
    qrr_div_cell u_cell (
      .clk_i, .rst_ni,
      .up_i       (dv_hs[j]),
      .up_ready_o (dv_rdy[j]),
      .ctx_i      (dv_ctx[j]),
      .hi_i       (dv_hi[j]),
      .lo_i       (dv_lo[j]),
      .dn_o       (dv_hs[j+1]),
      .dn_ready_i (dv_rdy[j+1]),
      .ctx_o      (dv_ctx[j+1]),
      .hi_o       (dv_hi[j+1]),
      .lo_o       (dv_lo[j+1])
    );
  end

  // output stage
  function automatic logic signed [ROOT_WIDTH-1:0] sat_root(
    input logic signed [CMP_WIDTH-1:0] r
  );
    logic signed [CMP_WIDTH-1:0] rmax, rmin;
    rmax = signed'(CMP_WIDTH'({1'b0, {(ROOT_WIDTH-1){1'b1}}}));
    rmin = signed'({{(CMP_WIDTH-ROOT_WIDTH+1){1'b1}}, {(ROOT_WIDTH-1){1'b0}}});
    priority if (r > rmax) return rmax[ROOT_WIDTH-1:0];
    else if (r < rmin)     return rmin[ROOT_WIDTH-1:0];
    else                   return r[ROOT_WIDTH-1:0];
  endfunction

  logic                         ov_q, o_adv;
  status_e                      ost_q;
  logic signed [ROOT_WIDTH-1:0] ohi_q, olo_q, ohi_d, olo_d, r1, r2;
  logic signed [CMP_WIDTH-1:0]  w1, w2;

  assign o_adv = !ov_q || out_o.ready;
  assign dv_rdy[NUM_WIDTH] = o_adv;

  always_comb begin
    w1 = CMP_WIDTH'(signed'({1'b0, dv_hi[NUM_WIDTH].quo}));
    w2 = CMP_WIDTH'(signed'({1'b0, dv_lo[NUM_WIDTH].quo}));
    if (dv_ctx[NUM_WIDTH].neg_hi) w1 = -w1;
    if (dv_ctx[NUM_WIDTH].neg_lo) w2 = -w2;
    r1 = sat_root(w1);
    r2 = sat_root(w2);
    if (dv_ctx[NUM_WIDTH].status == ST_NONE || dv_ctx[NUM_WIDTH].status == ST_AZERO) begin
      ohi_d = '0;
      olo_d = '0;
    end else if (r2 > r1) begin
      ohi_d = r2;
      olo_d = r1;
    end else begin
      ohi_d = r1;
      olo_d = r2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (o_adv) begin
      ov_q <= dv_hs[NUM_WIDTH].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_adv && dv_hs[NUM_WIDTH].valid) begin
      ost_q <= dv_ctx[NUM_WIDTH].status;
      ohi_q <= ohi_d;
      olo_q <= olo_d;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.root_status = ost_q;
  assign out_o.root_high   = ohi_q;
  assign out_o.root_low    = olo_q;

endmodule

// File: sv/qrr_checker.sv
`timescale 1ns / 1ps

module qrr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_i,
  input logic                                  out_ready_i,
  input logic [1:0]                            status_i,
  input logic signed [qrr_pkg::ROOT_WIDTH-1:0] high_i,
  input logic signed [qrr_pkg::ROOT_WIDTH-1:0] low_i
);
  import qrr_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(high_i) && $stable(low_i))
    else $error("result dropped while stalled");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_NONE || status_i == ST_AZERO) |->
      high_i == '0 && low_i == '0)
    else $error("roots not zero without real roots");

  a_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_DOUBLE |-> high_i == low_i)
    else $error("double root differs");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_TWO |-> high_i >= low_i)
    else $error("roots out of order");

endmodule

bind quadratic_real_roots_unit qrr_checker u_qrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.root_status),
  .high_i      (out_o.root_high),
  .low_i       (out_o.root_low)
);
